### rtl/assert_macros.svh
// Assertion macros shared by the range mapper modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define AARM_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset
`define AARM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/aarm_pkg.sv
// Shared types and constants of the averaged ADC range mapper
package aarm_pkg;

  localparam int LEVEL_W        = 13;
  localparam int RANGE_W        = 14;
  localparam int OUT_W          = 21;
  localparam int FRAC_W         = 8;
  localparam int WIN_W          = 5;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 13;
  localparam int ADC_FULL_SCALE = 8192;
  localparam int FS_LOG2        = $clog2(ADC_FULL_SCALE);
  localparam int MAX_WINDOW_DEF = 16;
  localparam int SMALL_SPAN     = 200;
  localparam int PLAIN_STEP     = 16;
  localparam int QDEPTH         = 2;
  localparam int Q_PTR_W        = $clog2(QDEPTH);
  localparam int Q_CNT_W        = $clog2(QDEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OUTPUT_LOW    = 3'd0,
    REG_OUTPUT_HIGH   = 3'd1,
    REG_QUANTISE_MODE = 3'd2,
    REG_AVERAGE_MODE  = 3'd3,
    REG_WINDOW_SIZE   = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic               quantise;
    logic               average;
    logic [WIN_W-1:0]   window;
    logic [LEVEL_W-1:0] lo;
    logic [RANGE_W-1:0] span;
    logic               small_span;
  } cfg_t;

endpackage

### rtl/aarm_cfg.sv
// Configuration registers and derived range bounds
module aarm_cfg #(
  parameter int MAX_WINDOW = aarm_pkg::MAX_WINDOW_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [aarm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [aarm_pkg::CFG_DATA_W-1:0] cfg_data,
  output aarm_pkg::cfg_t                 cfg,
  output logic                           win_clr
);
  import aarm_pkg::*;

  logic [LEVEL_W-1:0] out_low;
  logic [LEVEL_W-1:0] out_high;
  logic               quantise;
  logic               average;
  logic [WIN_W-1:0]   window;
  logic [LEVEL_W-1:0] lo;
  logic [RANGE_W-1:0] span;
  logic               small_span;
  logic [WIN_W-1:0]   win_next;
  logic [LEVEL_W-1:0] lo_next;
  logic [LEVEL_W-1:0] hi_next;
  logic [RANGE_W-1:0] span_next;
  logic               wr;

  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid && cfg_ready;
  assign win_clr   = wr && (cfg_index == REG_WINDOW_SIZE);

  always_comb begin
    win_next = cfg_data[WIN_W-1:0];
    if (win_next == '0) begin
      win_next = WIN_W'(1);
    end else if (32'(win_next) > MAX_WINDOW) begin
      win_next = WIN_W'(MAX_WINDOW);
    end
    if (out_low > out_high) begin
      lo_next = out_high;
      hi_next = out_low;
    end else begin
      lo_next = out_low;
      hi_next = out_high;
    end
    span_next = RANGE_W'(hi_next) - RANGE_W'(lo_next) + RANGE_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_low    <= '0;
      out_high   <= '1;
      quantise   <= 1'b0;
      average    <= 1'b0;
      window     <= WIN_W'(1);
      lo         <= '0;
      span       <= RANGE_W'(ADC_FULL_SCALE);
      small_span <= 1'b0;
    end else begin
      if (wr) begin
        unique case (cfg_index)
          REG_OUTPUT_LOW:    out_low  <= cfg_data[LEVEL_W-1:0];
          REG_OUTPUT_HIGH:   out_high <= cfg_data[LEVEL_W-1:0];
          REG_QUANTISE_MODE: quantise <= cfg_data[0];
          REG_AVERAGE_MODE:  average  <= cfg_data[0];
          REG_WINDOW_SIZE:   window   <= win_next;
          default: ;
        endcase
      end
      lo         <= lo_next;
      span       <= span_next;
      small_span <= quantise && (span_next < RANGE_W'(SMALL_SPAN));
    end
  end

  assign cfg = {quantise, average, window, lo, span, small_span};

endmodule

### rtl/aarm_front.sv
// Sample accumulator that closes windows and queues their sums
module aarm_front #(
  parameter int SUM_W      = 17,
  parameter int CNT_W      = 5
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [aarm_pkg::LEVEL_W-1:0]  sample,
  input  aarm_pkg::cfg_t                cfg,
  input  logic                          win_clr,
  input  logic                          q_full,
  output logic                          q_push,
  output logic [SUM_W-1:0]              q_data
);
  import aarm_pkg::*;
  `include "assert_macros.svh"

  logic [SUM_W-1:0] sum;
  logic [CNT_W-1:0] count;
  logic [SUM_W-1:0] sum_next;
  logic             accept;
  logic             full_win;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;
  assign sum_next = sum + SUM_W'(sample);
  assign full_win = (WIN_W+1)'(count) + (WIN_W+1)'(1) >= (WIN_W+1)'(cfg.window);
  assign q_push   = accept && full_win;
  assign q_data   = sum_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      sum   <= '0;
      count <= '0;
    end else if (win_clr) begin
      sum   <= '0;
      count <= '0;
    end else if (accept) begin
      if (full_win) begin
        sum   <= '0;
        count <= '0;
      end else begin
        sum   <= sum_next;
        count <= count + CNT_W'(1);
      end
    end
  end

  `AARM_ASSERT_IMP(a_count_below_window, clk, rst, 1'b1,
                   (WIN_W+1)'(count) < (WIN_W+1)'(cfg.window))

endmodule

### rtl/aarm_queue.sv
// Two-entry queue of window sums between accumulator and evaluator
module aarm_queue #(
  parameter int SUM_W = 17
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [SUM_W-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output logic [SUM_W-1:0] pop_data
);
  import aarm_pkg::*;
  `include "assert_macros.svh"

  logic [SUM_W-1:0]   mem [QDEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;
  logic               do_push;
  logic               do_pop;

  assign full     = count == Q_CNT_W'(QDEPTH);
  assign empty    = count == '0;
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + Q_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + Q_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + Q_CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - Q_CNT_W'(1);
      end
    end
  end

  `AARM_ASSERT_IMP(a_queue_bound, clk, rst, 1'b1, count <= Q_CNT_W'(QDEPTH))
  `AARM_ASSERT_NEXT(a_queue_ptr_gap, clk, rst, 1'b1, Q_PTR_W'(wr_ptr - rd_ptr) == Q_PTR_W'(count))

endmodule

### rtl/aarm_back.sv
// Evaluator: serial divide, threshold tests, range mapping, result beat
module aarm_back #(
  parameter int SUM_W = 17
) (
  input  logic                        clk,
  input  logic                        rst,
  input  aarm_pkg::cfg_t              cfg,
  input  logic                        q_empty,
  input  logic [SUM_W-1:0]            q_data,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [aarm_pkg::OUT_W-1:0]  mapped_value
);
  import aarm_pkg::*;
  `include "assert_macros.svh"

  localparam int REM_W   = WIN_W + 1;
  localparam int DCNT_W  = $clog2(SUM_W);
  localparam int MA_W    = LEVEL_W + 4;
  localparam int PROD_W  = MA_W + RANGE_W;
  localparam int WIDE_W  = PROD_W + FRAC_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_LOWMUL,
    ST_LOWCMP,
    ST_DIFF,
    ST_DMUL,
    ST_MAPMUL,
    ST_DECIDE
  } state_t;

  state_t             state;
  logic [DCNT_W-1:0]  cnt;
  logic [REM_W-1:0]   rem;
  logic [SUM_W-1:0]   dvd;
  logic [LEVEL_W-1:0] level;
  logic [LEVEL_W-1:0] diff;
  logic [PROD_W-1:0]  prod;
  logic               pass;
  logic [LEVEL_W-1:0] last_change_level;
  logic [LEVEL_W-1:0] previous_level;
  logic [OUT_W-1:0]   current_value;

  logic [REM_W-1:0]   rem_sh;
  logic               ge;
  logic [MA_W-1:0]    mul_a;
  logic [PROD_W-1:0]  mul_p;
  logic               plain;
  logic               quant_path;
  logic [LEVEL_W-1:0] ref_level;
  logic [WIDE_W-1:0]  wide_fix;
  logic [RANGE_W-1:0] int_part;
  logic [OUT_W-1:0]   mapped;
  logic               emit;
  logic               out_free;

  assign plain      = !cfg.average && !cfg.quantise;
  assign quant_path = !cfg.average && cfg.quantise;
  assign ref_level  = plain ? previous_level : last_change_level;
  assign out_free   = !out_valid || !out_stall;
  assign q_pop      = (state == ST_IDLE) && !q_empty;

  assign rem_sh = {rem[REM_W-2:0], dvd[SUM_W-1]};
  assign ge     = rem_sh >= REM_W'(cfg.window);

  always_comb begin
    unique case (state)
      ST_LOWMUL: mul_a = {dvd[LEVEL_W-1:0], 4'b0000} + MA_W'(1);
      ST_DMUL:   mul_a = MA_W'(diff);
      default:   mul_a = MA_W'(level);
    endcase
  end
  assign mul_p = PROD_W'(mul_a) * PROD_W'(cfg.span);

  always_comb begin
    wide_fix = {prod, {FRAC_W{1'b0}}} >> FS_LOG2;
    int_part = RANGE_W'(prod >> FS_LOG2) + RANGE_W'(cfg.lo);
    if (quant_path) begin
      mapped = OUT_W'({int_part, {FRAC_W{1'b0}}});
    end else begin
      mapped = OUT_W'(wide_fix + (WIDE_W'(cfg.lo) << FRAC_W));
    end
    emit = pass && (!quant_path || (mapped != current_value));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      out_valid         <= 1'b0;
      last_change_level <= '0;
      previous_level    <= '0;
      current_value     <= '0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            dvd   <= q_data;
            rem   <= '0;
            cnt   <= DCNT_W'(SUM_W - 1);
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem <= ge ? rem_sh - REM_W'(cfg.window) : rem_sh;
          dvd <= {dvd[SUM_W-2:0], ge};
          cnt <= cnt - DCNT_W'(1);
          if (cnt == '0) begin
            state <= ST_LOWMUL;
          end
        end
        ST_LOWMUL: begin
          level <= dvd[LEVEL_W-1:0];
          prod  <= mul_p;
          state <= ST_LOWCMP;
        end
        ST_LOWCMP: begin
          if (cfg.average) begin
            if (cfg.small_span ? (prod <= PROD_W'(4 * ADC_FULL_SCALE))
                               : (level < LEVEL_W'(PLAIN_STEP))) begin
              level <= '0;
            end
          end
          state <= ST_DIFF;
        end
        ST_DIFF: begin
          diff  <= (level > ref_level) ? level - ref_level : ref_level - level;
          state <= ST_DMUL;
        end
        ST_DMUL: begin
          prod  <= mul_p;
          state <= ST_MAPMUL;
        end
        ST_MAPMUL: begin
          pass  <= cfg.small_span ? ({prod, 2'b00} > (PROD_W+2)'(ADC_FULL_SCALE))
                                  : (diff > LEVEL_W'(PLAIN_STEP));
          prod  <= mul_p;
          state <= ST_DECIDE;
        end
        ST_DECIDE: begin
          if (out_free) begin
            if (emit) begin
              current_value <= mapped;
              mapped_value  <= mapped;
              out_valid     <= 1'b1;
              if (plain) begin
                previous_level <= level;
              end else begin
                last_change_level <= level;
              end
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `AARM_ASSERT_IMP(a_div_rem_bound, clk, rst, state == ST_DIV, rem < REM_W'(cfg.window))
  `AARM_ASSERT_NEXT(a_emit_loads_beat, clk, rst, state == ST_DECIDE && out_free && emit, out_valid && mapped_value == current_value)

endmodule

### rtl/averaged_adc_range_mapper.sv
// Top level of the averaged ADC range mapper
// Accepts one 13-bit sample per beat; every window_size samples the window
// sum goes through a two-entry queue to the evaluator, which divides it one
// quotient bit per cycle, runs threshold and mapping products through one
// shared multiplier and presents at most one Q13.8 result beat. After the
// bit-serial divide (SUM_W = 17 at the default window limit of 16) the
// evaluator steps through low multiply, compare, difference, difference
// multiply, map multiply and decide, taking a new sum only when idle, so
// the queue absorbs two more. Configuration is accepted every cycle.
module averaged_adc_range_mapper #(
  parameter int MAX_WINDOW = aarm_pkg::MAX_WINDOW_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [aarm_pkg::LEVEL_W-1:0]     sample,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [aarm_pkg::OUT_W-1:0]       mapped_value,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [aarm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [aarm_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import aarm_pkg::*;

  localparam int WIN_LIM = (MAX_WINDOW < 31) ? MAX_WINDOW : 31;
  localparam int SUM_W   = LEVEL_W + $clog2(WIN_LIM);
  localparam int CNT_W   = (WIN_LIM < 2) ? 1 : $clog2(WIN_LIM);

  cfg_t             cfg;
  logic             win_clr;
  logic             q_push;
  logic [SUM_W-1:0] q_wdata;
  logic             q_full;
  logic             q_pop;
  logic             q_empty;
  logic [SUM_W-1:0] q_rdata;

  aarm_cfg #(
    .MAX_WINDOW(MAX_WINDOW)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .win_clr   (win_clr)
  );

  aarm_front #(
    .SUM_W     (SUM_W),
    .CNT_W     (CNT_W)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sample   (sample),
    .cfg      (cfg),
    .win_clr  (win_clr),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_wdata)
  );

  aarm_queue #(
    .SUM_W(SUM_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .pop_data  (q_rdata)
  );

  aarm_back #(
    .SUM_W(SUM_W)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_empty      (q_empty),
    .q_data       (q_rdata),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .mapped_value (mapped_value)
  );

endmodule
